>>> rtl/core/tspw_pkg.sv
// Shared types and constants for the SPI display write framer.
package tspw_pkg;

  // Frame start bytes sent ahead of the index and the data of a register write.
  localparam logic [7:0] START_INDEX = 8'h70;
  localparam logic [7:0] START_DATA  = 8'h72;

  // Controller registers used by a pixel write.
  localparam logic [7:0] REG_XLO  = 8'h03;
  localparam logic [7:0] REG_XHI  = 8'h02;
  localparam logic [7:0] REG_YLO  = 8'h07;
  localparam logic [7:0] REG_YHI  = 8'h06;
  localparam logic [7:0] REG_GRAM = 8'h22;

  // Request kinds carried in the action field.
  localparam logic ACT_REG_WRITE   = 1'b0;
  localparam logic ACT_PIXEL_WRITE = 1'b1;

  // Byte counter width and the position of the final byte of each request kind.
  localparam int unsigned PosW = 5;
  localparam logic [PosW-1:0] REG_LAST_POS   = PosW'(4);
  localparam logic [PosW-1:0] PIXEL_LAST_POS = PosW'(24);

  typedef struct packed {
    logic        action;
    logic [7:0]  reg_index;
    logic [15:0] reg_value;
    logic [9:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] pixel_color;
  } req_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_end;
    logic       last;
  } sel_t;

endpackage

>>> rtl/core/tspw_byte_sel.sv
// Picks the wire byte, frame end and last flags for one byte position of a request.
module tspw_byte_sel (
  input  tspw_pkg::req_t                 req,
  input  logic [tspw_pkg::PosW-1:0]      pos,
  output tspw_pkg::sel_t                 sel
);

  logic [7:0] x_hi;
  logic [7:0] y_hi;

  assign x_hi = {6'b0, req.pixel_x[9:8]};
  assign y_hi = {6'b0, req.pixel_y[9:8]};

  always_comb begin
    sel = '0;
    if (req.action == tspw_pkg::ACT_REG_WRITE) begin
      case (pos)
        5'd0: sel.wire_byte = tspw_pkg::START_INDEX;
        5'd1: begin
          sel.wire_byte = req.reg_index;
          sel.frame_end = 1'b1;
        end
        5'd2: sel.wire_byte = tspw_pkg::START_DATA;
        5'd3: sel.wire_byte = req.reg_value[15:8];
        5'd4: begin
          sel.wire_byte = req.reg_value[7:0];
          sel.frame_end = 1'b1;
          sel.last      = 1'b1;
        end
        default: sel = '0;
      endcase
    end else begin
      case (pos)
        // Column low register gets the full coordinate.
        5'd0:  sel.wire_byte = tspw_pkg::START_INDEX;
        5'd1:  begin sel.wire_byte = tspw_pkg::REG_XLO; sel.frame_end = 1'b1; end
        5'd2:  sel.wire_byte = tspw_pkg::START_DATA;
        5'd3:  sel.wire_byte = x_hi;
        5'd4:  begin sel.wire_byte = req.pixel_x[7:0]; sel.frame_end = 1'b1; end
        // Column high register gets the coordinate shifted down by eight.
        5'd5:  sel.wire_byte = tspw_pkg::START_INDEX;
        5'd6:  begin sel.wire_byte = tspw_pkg::REG_XHI; sel.frame_end = 1'b1; end
        5'd7:  sel.wire_byte = tspw_pkg::START_DATA;
        5'd8:  sel.wire_byte = 8'h00;
        5'd9:  begin sel.wire_byte = x_hi; sel.frame_end = 1'b1; end
        // Row registers follow the same pattern.
        5'd10: sel.wire_byte = tspw_pkg::START_INDEX;
        5'd11: begin sel.wire_byte = tspw_pkg::REG_YLO; sel.frame_end = 1'b1; end
        5'd12: sel.wire_byte = tspw_pkg::START_DATA;
        5'd13: sel.wire_byte = y_hi;
        5'd14: begin sel.wire_byte = req.pixel_y[7:0]; sel.frame_end = 1'b1; end
        5'd15: sel.wire_byte = tspw_pkg::START_INDEX;
        5'd16: begin sel.wire_byte = tspw_pkg::REG_YHI; sel.frame_end = 1'b1; end
        5'd17: sel.wire_byte = tspw_pkg::START_DATA;
        5'd18: sel.wire_byte = 8'h00;
        5'd19: begin sel.wire_byte = y_hi; sel.frame_end = 1'b1; end
        // Graphics RAM index frame, then the colour.
        5'd20: sel.wire_byte = tspw_pkg::START_INDEX;
        5'd21: begin sel.wire_byte = tspw_pkg::REG_GRAM; sel.frame_end = 1'b1; end
        5'd22: sel.wire_byte = tspw_pkg::START_DATA;
        5'd23: sel.wire_byte = req.pixel_color[15:8];
        5'd24: begin
          sel.wire_byte = req.pixel_color[7:0];
          sel.frame_end = 1'b1;
          sel.last      = 1'b1;
        end
        default: sel = '0;
      endcase
    end
  end

endmodule

>>> rtl/core/tft_spi_pixel_frame_writer.sv
// Top level of the SPI display write framer: request register, byte counter, output register.
//
// The input channel (in_valid / in_ready) takes one request per transaction:
// either a single register write (in_action = 0) or a pixel write (in_action = 1).
// The result channel (out_valid / out_ready) gives one wire byte per transaction,
// in the order it is shifted out on the serial data line, MSB first. out_frame_end
// marks the byte after which chip select rises, and out_last marks the final byte
// of the request.
// A register write produces 5 bytes and a pixel write 25 bytes, one byte per
// cycle while the receiver keeps out_ready high; the byte counter walking through
// the held request sets that figure. A request is first captured in the request
// register, and its first byte then moves from there into the output register.
// The next request is taken in the same cycle in which the final byte of the
// current one moves into the output register, so requests follow each other
// without a gap.
// When the receiver stalls, the output register holds its byte and the counter
// stops; in_ready stays low until the final byte can move on.
// Reset (rst_n low, synchronous) empties the output register and leaves the
// block idle, ready for a request.
module tft_spi_pixel_frame_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_reg_index,
  input  logic [15:0] in_reg_value,
  input  logic [9:0]  in_pixel_x,
  input  logic [9:0]  in_pixel_y,
  input  logic [15:0] in_pixel_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_wire_byte,
  output logic        out_frame_end,
  output logic        out_last
);

  // Held request and position of the next byte to send.
  tspw_pkg::req_t              req_r;
  logic                        busy_r;
  logic [tspw_pkg::PosW-1:0]   pos_r;
  logic [tspw_pkg::PosW-1:0]   pos_nxt;

  // Output register.
  logic                        out_valid_r;
  tspw_pkg::sel_t              out_r;

  tspw_pkg::sel_t              cur_sel;
  logic                        advance;
  logic                        in_take;

  tspw_byte_sel u_byte_sel (
    .req (req_r),
    .pos (pos_r),
    .sel (cur_sel)
  );

  // A byte moves into the output register when one is pending and the
  // register is empty or being drained this cycle.
  assign advance  = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (advance && cur_sel.last);
  assign in_take  = in_valid && in_ready;
  assign pos_nxt  = pos_r + tspw_pkg::PosW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        busy_r <= 1'b1;
        pos_r  <= '0;
      end else if (advance) begin
        if (cur_sel.last) begin
          busy_r <= 1'b0;
          pos_r  <= '0;
        end else begin
          pos_r  <= pos_nxt;
        end
      end

      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.action      <= in_action;
      req_r.reg_index   <= in_reg_index;
      req_r.reg_value   <= in_reg_value;
      req_r.pixel_x     <= in_pixel_x;
      req_r.pixel_y     <= in_pixel_y;
      req_r.pixel_color <= in_pixel_color;
    end
    if (advance) begin
      out_r <= cur_sel;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_wire_byte = out_r.wire_byte;
  assign out_frame_end = out_r.frame_end;
  assign out_last      = out_r.last;

  // An idle sequencer always sits at the first byte position.
  a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (pos_r == '0))
    else $error("byte counter not at start while idle");

  // The counter never runs past the final byte of the held request kind.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((req_r.action == tspw_pkg::ACT_PIXEL_WRITE) ?
                (pos_r <= tspw_pkg::PIXEL_LAST_POS) :
                (pos_r <= tspw_pkg::REG_LAST_POS)))
    else $error("byte counter past final byte");

  // A new request is taken while busy only as the final byte moves on.
  a_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && busy_r) |-> (advance && cur_sel.last))
    else $error("request taken before current one finished");

  // Sending the final byte without a new request leaves the block idle.
  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_sel.last && !in_valid) |=> !busy_r)
    else $error("sequencer stayed busy after final byte");

  // Each byte that moves into the output register is shown next cycle.
  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("byte lost on the way to the output register");

endmodule
